/* hw/rtl/galois_field_arithmetic_unit_macros.svh */
// Assertion helpers shared by the arithmetic unit modules.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n.
`ifndef GALOIS_FIELD_ARITHMETIC_UNIT_MACROS_SVH
`define GALOIS_FIELD_ARITHMETIC_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GFAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GFAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/gfau_pkg.sv */
package gfau_pkg;

    // Fixed widths of the interface fields and the polynomial register.
    localparam int POLY_W   = 17;
    localparam int ELEM_W   = 16;
    localparam int DEG_W    = 5;
    localparam int DIGITS_W = 3;

    // Bits of the multiplier operand consumed by the shared unit per busy cycle.
    localparam int DIGIT_BITS = 4;

    // Smallest supported field degree.
    localparam logic [DEG_W-1:0] MIN_DEG = 5'd4;

    // Reset value of the field polynomial: x^8 + x^4 + x^3 + x^2 + 1.
    localparam logic [POLY_W-1:0] RESET_POLY = 17'h0011D;

    // Operation codes carried in the input tuser.
    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_MUL  = 2'd1;
    localparam logic [1:0] KIND_DIV  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // Status codes carried in the output tuser.
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO     = 2'd1;
    localparam logic [1:0] ST_OUT_OF_FIELD = 2'd2;

    // Register index of the field polynomial.
    localparam logic REG_FIELD_POLY = 1'b0;

    // Field description derived from the polynomial at configuration time.
    typedef struct packed {
        logic [POLY_W-1:0]   poly;
        logic [POLY_W-1:0]   top;       // one-hot bit at the degree
        logic [ELEM_W-1:0]   low_mask;  // bits below the degree
        logic [DEG_W-1:0]    deg;
        logic [DIGITS_W-1:0] digits;    // number of DIGIT_BITS digits per product
        logic                ok;        // degree is at least MIN_DEG
    } t_field;

    // Derive the field description from a polynomial. The upper degree limit
    // depends on a module parameter and is applied by the caller.
    function automatic t_field derive_field(input logic [POLY_W-1:0] p);
        t_field           f;
        logic [DEG_W-1:0] d;
        logic [DEG_W:0]   d_sum;
        d = '0;
        for (int i = 0; i < POLY_W; i++) begin
            if (p[i]) begin
                d = DEG_W'(i);
            end
        end
        d_sum      = {1'b0, d} + (DEG_W + 1)'(DIGIT_BITS - 1);
        f.poly     = p;
        f.top      = POLY_W'(1) << d;
        f.low_mask = ELEM_W'(f.top - POLY_W'(1));
        f.deg      = d;
        f.digits   = DIGITS_W'(d_sum >> 2);
        f.ok       = (p != '0) && (d >= MIN_DEG);
        return f;
    endfunction

endpackage

/* hw/rtl/gfau_cfg.sv */
// Configuration register block: holds the field polynomial and the field
// description derived from it at write time.
module gfau_cfg #(
    parameter int MAX_DEGREE = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output gfau_pkg::t_field    o_field
);

    gfau_pkg::t_field r_field;
    gfau_pkg::t_field n_field;
    gfau_pkg::t_field w_new;
    gfau_pkg::t_field w_rst;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == gfau_pkg::REG_FIELD_POLY);

    // New description from the written polynomial, with the upper degree limit.
    // The reset description gets the same limit.
    always_comb begin
        w_new    = gfau_pkg::derive_field(pwdata[gfau_pkg::POLY_W-1:0]);
        w_new.ok = w_new.ok && (w_new.deg <= gfau_pkg::DEG_W'(MAX_DEGREE));
        w_rst    = gfau_pkg::derive_field(gfau_pkg::RESET_POLY);
        w_rst.ok = w_rst.ok && (w_rst.deg <= gfau_pkg::DEG_W'(MAX_DEGREE));
        n_field  = w_wr ? w_new : r_field;
    end

    // Field register; reset restores the default polynomial.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field <= w_rst;
        end else begin
            r_field <= n_field;
        end
    end

    // Reads return the polynomial; other addresses read as zero.
    always_comb begin
        prdata = '0;
        if (paddr[2] == gfau_pkg::REG_FIELD_POLY) begin
            prdata = 32'(r_field.poly);
        end
    end

    assign o_field = r_field;

endmodule

/* hw/rtl/gfau_mul.sv */
`include "galois_field_arithmetic_unit_macros.svh"

// Shared shift-and-reduce multiplier. Each busy cycle consumes DIGIT_BITS
// bits of the multiplier, low bits first; o_done pulses once the product is
// in o_prod.
module gfau_mul #(
    parameter int W = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [W-1:0]                  i_a,
    input  logic [W-1:0]                  i_b,
    input  logic [W:0]                    i_poly,
    input  logic [W:0]                    i_top,
    input  logic [gfau_pkg::DIGITS_W-1:0] i_digits,
    output logic [W-1:0]                  o_prod,
    output logic                          o_done
);

    logic [W-1:0]                  r_acc;
    logic [W-1:0]                  r_a;
    logic [W-1:0]                  r_b;
    logic [gfau_pkg::DIGITS_W-1:0] r_cnt;
    logic                          r_done;
    logic [W-1:0]                  n_acc;
    logic [W-1:0]                  n_a;

    // One digit of shift-and-reduce steps.
    always_comb begin
        logic [W:0] sh;
        n_acc = r_acc;
        n_a   = r_a;
        for (int k = 0; k < gfau_pkg::DIGIT_BITS; k++) begin
            if (r_b[k]) begin
                n_acc = n_acc ^ n_a;
            end
            sh = {n_a, 1'b0};
            if ((sh & i_top) != '0) begin
                sh = sh ^ i_poly;
            end
            n_a = sh[W-1:0];
        end
    end

    // Control: counter of digit cycles and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= i_digits;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == gfau_pkg::DIGITS_W'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - gfau_pkg::DIGITS_W'(1);
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_cnt != '0) begin
            r_acc <= n_acc;
            r_a   <= n_a;
            r_b   <= r_b >> gfau_pkg::DIGIT_BITS;
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

    `GFAU_ASSERT_NOW(a_start_idle, i_start, r_cnt == '0, "multiplier started while busy")
    `GFAU_ASSERT_NOW(a_done_idle, r_done, r_cnt == '0, "done raised with digits left")
    `GFAU_ASSERT_NEXT(a_start_runs, i_start && (i_digits != '0), r_cnt != '0,
                      "multiplier did not begin after start")

endmodule

/* hw/rtl/galois_field_arithmetic_unit.sv */
// Channel   | Direction | Signals                               | Item
// s_axis    | in        | tvalid tready tdata[31:0] tuser[1:0]  | operation and two operands
// m_axis    | out       | tvalid tready tdata[15:0] tuser[1:0]  | result value and status
// APB       | in/out    | psel penable pwrite paddr pwdata ...  | field polynomial register
//
// Add, errors and zero operands show their result on the cycle after the item is accepted.
// A multiply is one product; a divide chains 2(m-1)+1 such products, all on the one
// shared multiplier. s_axis_tready is low while an item is in the multiplier, or
// while a result waits and m_axis_tready is low. The next item can be taken once the
// result is out. Reset is synchronous and active low; it restores the polynomial 0x11D.
`include "galois_field_arithmetic_unit_macros.svh"

module galois_field_arithmetic_unit #(
    parameter int MAX_DEGREE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // operand_a[15:0], operand_b[31:16]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // value[15:0]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int W      = MAX_DEGREE;
    localparam int ITER_W = $clog2(MAX_DEGREE);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SQR  = 2'd1;
    localparam logic [1:0] S_RMUL = 2'd2;
    localparam logic [1:0] S_MUL  = 2'd3;

    gfau_pkg::t_field w_field;

    logic [1:0]        r_state,  n_state;
    logic [W-1:0]      r_x,      n_x;
    logic [W-1:0]      r_r,      n_r;
    logic [W-1:0]      r_s,      n_s;
    logic [ITER_W-1:0] r_iter,   n_iter;
    logic              r_out_valid, n_out_valid;
    logic [15:0]       r_out_value, n_out_value;
    logic [1:0]        r_out_status, n_out_status;

    logic         w_accept;
    logic         w_start;
    logic [W-1:0] w_ma;
    logic [W-1:0] w_mb;
    logic [W-1:0] w_prod;
    logic         w_done;
    logic [1:0]   w_kind;
    logic [15:0]  w_a;
    logic [15:0]  w_b;
    logic         w_bad;

    gfau_cfg #(
        .MAX_DEGREE(MAX_DEGREE)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_field (w_field)
    );

    gfau_mul #(
        .W(W)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_a      (w_ma),
        .i_b      (w_mb),
        .i_poly   (w_field.poly[W:0]),
        .i_top    (w_field.top[W:0]),
        .i_digits (w_field.digits),
        .o_prod   (w_prod),
        .o_done   (w_done)
    );

    // Input unpacking and field checks.
    assign w_kind = s_axis_tuser;
    assign w_a    = s_axis_tdata[15:0];
    assign w_b    = s_axis_tdata[31:16];
    assign w_bad  = !w_field.ok || (w_kind == gfau_pkg::KIND_NONE)
                    || ((w_a & ~w_field.low_mask) != '0)
                    || ((w_b & ~w_field.low_mask) != '0);

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Sequencer: the inverse is b^(2^m-2), built by m-1 squarings and products.
    always_comb begin
        n_state      = r_state;
        n_x          = r_x;
        n_r          = r_r;
        n_s          = r_s;
        n_iter       = r_iter;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        w_start      = 1'b0;
        w_ma         = w_prod;
        w_mb         = w_prod;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_value  = '0;
                    n_out_status = gfau_pkg::ST_OK;
                    n_out_valid  = 1'b1;
                    if (w_bad) begin
                        n_out_status = gfau_pkg::ST_OUT_OF_FIELD;
                    end else if (w_kind == gfau_pkg::KIND_ADD) begin
                        n_out_value = w_a ^ w_b;
                    end else if (w_kind == gfau_pkg::KIND_MUL) begin
                        if ((w_a != '0) && (w_b != '0)) begin
                            n_out_valid = 1'b0;
                            w_start     = 1'b1;
                            w_ma        = w_a[W-1:0];
                            w_mb        = w_b[W-1:0];
                            n_state     = S_MUL;
                        end
                    end else if (w_a != '0) begin
                        if (w_b == '0) begin
                            n_out_status = gfau_pkg::ST_DIV_ZERO;
                        end else begin
                            n_out_valid = 1'b0;
                            n_x         = w_a[W-1:0];
                            n_r         = W'(1);
                            n_iter      = ITER_W'(w_field.deg - gfau_pkg::DEG_W'(1));
                            w_start     = 1'b1;
                            w_ma        = w_b[W-1:0];
                            w_mb        = w_b[W-1:0];
                            n_state     = S_SQR;
                        end
                    end
                end
            end
            S_SQR: begin
                if (w_done) begin
                    n_s     = w_prod;
                    w_start = 1'b1;
                    w_ma    = r_r;
                    w_mb    = w_prod;
                    n_state = S_RMUL;
                end
            end
            S_RMUL: begin
                if (w_done) begin
                    n_r     = w_prod;
                    w_start = 1'b1;
                    if (r_iter == ITER_W'(1)) begin
                        w_ma    = r_x;
                        w_mb    = w_prod;
                        n_state = S_MUL;
                    end else begin
                        n_iter  = r_iter - ITER_W'(1);
                        w_ma    = r_s;
                        w_mb    = r_s;
                        n_state = S_SQR;
                    end
                end
            end
            S_MUL: begin
                if (w_done) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = 16'(w_prod);
                    n_out_status = gfau_pkg::ST_OK;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_x          <= n_x;
        r_r          <= n_r;
        r_s          <= n_s;
        r_iter       <= n_iter;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_status;

    `GFAU_ASSERT_NOW(a_err_zero, r_out_valid && (r_out_status != gfau_pkg::ST_OK),
                     r_out_value == '0, "error result carries a nonzero value")
    `GFAU_ASSERT_NOW(a_ready_idle, s_axis_tready, r_state == S_IDLE,
                     "ready raised while an item is in progress")
    `GFAU_ASSERT_NOW(a_done_busy, w_done, r_state != S_IDLE,
                     "multiplier finished with no item in progress")
    `GFAU_ASSERT_NEXT(a_busy_no_out, w_accept && w_start, !r_out_valid,
                      "result shown before the multiplier finished")

endmodule

/* test/galois_field_arithmetic_unit_tb.sv */
module galois_field_arithmetic_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POLY_W         = gfau_pkg::POLY_W;
    localparam int ELEM_W         = gfau_pkg::ELEM_W;
    localparam int CLK_PERIOD     = 20;
    localparam int FIELD_MAX_DEG  = 16;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLDOFF_AT     = 150;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int MAX_PRINTS     = 200;
    localparam int PHASES         = 10;
    localparam int NO_GAP_PHASE   = 1;
    localparam logic [2:0] FIELD_POLY_ADDR = {gfau_pkg::REG_FIELD_POLY, 2'b00};

    typedef struct packed {
        logic [1:0]        kind;
        logic [ELEM_W-1:0] operand_a;
        logic [ELEM_W-1:0] operand_b;
    } t_gf_request;

    typedef struct packed {
        t_gf_request       request;
        logic [ELEM_W-1:0] value;
        logic [1:0]        status;
    } t_gf_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // operand_a[15:0], operand_b[31:16]
    logic [1:0]  s_axis_tuser = '0;    // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // value[15:0]
    logic [1:0]  m_axis_tuser;         // status[1:0]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_gf_request       pending_requests[$];
    t_gf_answer        expected_answers[$];
    t_gf_request       current_request;
    logic [POLY_W-1:0] field_poly_shadow = gfau_pkg::RESET_POLY;
    bit                gaps_on = 1'b1;
    int                error_count = 0;
    int                results_seen = 0;
    int                holdoff_left = 0;
    int                cycle_count = 0;

    galois_field_arithmetic_unit #(
        .MAX_DEGREE(FIELD_MAX_DEG)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Degree of the polynomial, or -1 for the zero polynomial.
    function automatic int field_degree(input logic [POLY_W-1:0] poly);
        int deg;
        deg = -1;
        for (int i = 0; i < POLY_W; i++) begin
            if (poly[i]) begin
                deg = i;
            end
        end
        return deg;
    endfunction

    // Shift-and-reduce product of two elements below 2^m.
    function automatic logic [POLY_W-1:0] gf_product(input logic [POLY_W-1:0] a,
                                                     input logic [POLY_W-1:0] b,
                                                     input int m,
                                                     input logic [POLY_W-1:0] poly);
        logic [POLY_W-1:0] acc;
        logic [POLY_W-1:0] shifted;
        acc = '0;
        shifted = a;
        for (int i = 0; i < m; i++) begin
            if (b[i]) begin
                acc ^= shifted;
            end
            shifted = shifted << 1;
            if (shifted[m]) begin
                shifted ^= poly;
            end
        end
        return acc;
    endfunction

    // Inverse as b^(2^m - 2): the product of the squares b^(2^i), i = 1..m-1.
    function automatic logic [POLY_W-1:0] gf_inverse(input logic [POLY_W-1:0] b,
                                                     input int m,
                                                     input logic [POLY_W-1:0] poly);
        logic [POLY_W-1:0] acc;
        logic [POLY_W-1:0] square;
        acc = POLY_W'(1);
        square = b;
        for (int i = 1; i < m; i++) begin
            square = gf_product(square, square, m, poly);
            acc = gf_product(acc, square, m, poly);
        end
        return acc;
    endfunction

    // Expected value and status of one operation under the given polynomial.
    function automatic t_gf_answer gf_compute(input t_gf_request req,
                                              input logic [POLY_W-1:0] poly);
        t_gf_answer        ans;
        int                m;
        logic [POLY_W-1:0] a;
        logic [POLY_W-1:0] b;
        m = field_degree(poly);
        a = POLY_W'(req.operand_a);
        b = POLY_W'(req.operand_b);
        ans.request = req;
        ans.value = '0;
        ans.status = gfau_pkg::ST_OK;
        if (m < int'(gfau_pkg::MIN_DEG) || m > FIELD_MAX_DEG
            || req.kind == gfau_pkg::KIND_NONE) begin
            ans.status = gfau_pkg::ST_OUT_OF_FIELD;
        end else if ((a >> m) != '0 || (b >> m) != '0) begin
            // The field check wins over a zero divisor.
            ans.status = gfau_pkg::ST_OUT_OF_FIELD;
        end else if (req.kind == gfau_pkg::KIND_ADD) begin
            ans.value = ELEM_W'(a ^ b);
        end else if (req.kind == gfau_pkg::KIND_MUL) begin
            if (a != '0 && b != '0) begin
                ans.value = ELEM_W'(gf_product(a, b, m, poly));
            end
        end else if (a != '0) begin
            if (b == '0) begin
                ans.status = gfau_pkg::ST_DIV_ZERO;
            end else begin
                ans.value = ELEM_W'(gf_product(a, gf_inverse(b, m, poly), m, poly));
            end
        end
        return ans;
    endfunction

    // Mostly in-field values, with zero, one, all ones and values just past the field.
    function automatic logic [ELEM_W-1:0] pick_operand(input int m);
        logic [POLY_W-1:0] span;
        int                r;
        span = POLY_W'(1) << m;
        r = $urandom_range(99);
        if (r < 8) return '0;
        if (r < 14) return ELEM_W'(span - 1);
        if (r < 18) return ELEM_W'(1);
        if (r < 24) return ELEM_W'($urandom);
        if (r < 27) return ELEM_W'(span);
        return ELEM_W'($urandom) & ELEM_W'(span - 1);
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic push_request(input logic [1:0] kind, input logic [ELEM_W-1:0] a,
                                input logic [ELEM_W-1:0] b);
        t_gf_request req;
        req.kind = kind;
        req.operand_a = a;
        req.operand_b = b;
        pending_requests.push_back(req);
    endtask

    task automatic queue_random_requests(input int count);
        int         m;
        int         r;
        logic [1:0] kind;
        m = field_degree(field_poly_shadow);
        repeat (count) begin
            r = $urandom_range(99);
            kind = (r < 25) ? gfau_pkg::KIND_ADD :
                   (r < 55) ? gfau_pkg::KIND_MUL :
                   (r < 96) ? gfau_pkg::KIND_DIV : gfau_pkg::KIND_NONE;
            push_request(kind, pick_operand(m), pick_operand(m));
        end
    endtask

    // Block until every queued item went in and every result came back. The check
    // runs mid-cycle, after the driver's updates at the rising edge have landed.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || expected_answers.size() != 0
               || s_axis_tvalid);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the field polynomial, with junk in the unused upper bits, and read it back.
    task automatic write_field_poly(input logic [POLY_W-1:0] poly);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= FIELD_POLY_ADDR;
        pwdata <= {15'($urandom), poly};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        field_poly_shadow = poly;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata != 32'(poly)) begin
            report_mismatch($sformatf("field_poly read %h, expected %h", prdata, poly));
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Request driver: accepted items turn into expected answers under the current polynomial.
    always @(posedge i_clk) begin : request_driver
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_answers.push_back(gf_compute(current_request, field_poly_shadow));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_requests.size() != 0 && !(gaps_on && $urandom_range(99) < 20)) begin
                    current_request = pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {current_request.operand_b, current_request.operand_a};
                    s_axis_tuser <= current_request.kind;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls, including one long hold-off.
    always @(posedge i_clk) begin : result_monitor
        t_gf_answer want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %h status %0d",
                                              m_axis_tdata, m_axis_tuser));
                end else begin
                    want = expected_answers.pop_front();
                    if (m_axis_tdata != want.value) begin
                        report_mismatch($sformatf("kind %0d a %h b %h: value %h, expected %h",
                            want.request.kind, want.request.operand_a,
                            want.request.operand_b, m_axis_tdata, want.value));
                    end
                    if (m_axis_tuser != want.status) begin
                        report_mismatch($sformatf("kind %0d a %h b %h: status %0d, expected %0d",
                            want.request.kind, want.request.operand_a,
                            want.request.operand_b, m_axis_tuser, want.status));
                    end
                end
                results_seen++;
                if (results_seen == HOLDOFF_AT) begin
                    holdoff_left = HOLDOFF_CYCLES;
                end
            end
            if (holdoff_left != 0) begin
                holdoff_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(gaps_on && $urandom_range(99) < 20);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus: directed and random cases in the reset field, then one random phase per polynomial.
    initial begin : stimulus
        logic [POLY_W-1:0] phase_poly [PHASES];
        int                phase_count [PHASES];
        int                deg;

        phase_poly = '{17'h00013, 17'h1100B, 17'h0011B, 17'h00211, 17'h0, 17'h0,
                       17'h0000F, 17'h1FFFF, 17'h00010, gfau_pkg::RESET_POLY};
        phase_count = '{120, 220, 120, 120, 100, 100, 20, 80, 60, 100};
        // Two phases use a random polynomial of random degree.
        for (int i = 4; i < 6; i++) begin
            deg = $urandom_range(FIELD_MAX_DEG, int'(gfau_pkg::MIN_DEG));
            phase_poly[i] = (POLY_W'(1) << deg)
                            | (POLY_W'($urandom) & ((POLY_W'(1) << deg) - 1));
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset field, m = 8.
        push_request(gfau_pkg::KIND_ADD, 16'h0000, 16'h0000);
        push_request(gfau_pkg::KIND_ADD, 16'h00FF, 16'h00FF);
        push_request(gfau_pkg::KIND_ADD, 16'h00A5, 16'h005A);
        push_request(gfau_pkg::KIND_MUL, 16'h0000, 16'h0037);
        push_request(gfau_pkg::KIND_MUL, 16'h0037, 16'h0000);
        push_request(gfau_pkg::KIND_MUL, 16'h00FF, 16'h00FF);
        push_request(gfau_pkg::KIND_MUL, 16'h0080, 16'h0002);
        push_request(gfau_pkg::KIND_MUL, 16'h0001, 16'h00C3);
        push_request(gfau_pkg::KIND_DIV, 16'h0000, 16'h0000);
        push_request(gfau_pkg::KIND_DIV, 16'h0000, 16'h0009);
        push_request(gfau_pkg::KIND_DIV, 16'h0009, 16'h0000);
        push_request(gfau_pkg::KIND_DIV, 16'h00FF, 16'h00FF);
        push_request(gfau_pkg::KIND_DIV, 16'h0001, 16'h0053);
        push_request(gfau_pkg::KIND_DIV, 16'h0053, 16'h0001);
        push_request(gfau_pkg::KIND_DIV, 16'h0100, 16'h0000);
        push_request(gfau_pkg::KIND_DIV, 16'hFFFF, 16'h0000);
        push_request(gfau_pkg::KIND_ADD, 16'h0001, 16'hFFFF);
        push_request(gfau_pkg::KIND_MUL, 16'hFFFF, 16'hFFFF);
        push_request(gfau_pkg::KIND_NONE, 16'h0003, 16'h0004);
        push_request(gfau_pkg::KIND_NONE, 16'h0000, 16'h0000);
        queue_random_requests(200);
        wait_drained();

        for (int i = 0; i < PHASES; i++) begin
            gaps_on <= (i != NO_GAP_PHASE);
            write_field_poly(phase_poly[i]);
            queue_random_requests(phase_count[i]);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_answers.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_answers.size()));
        end
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/gfau_pkg.sv
hw/rtl/gfau_cfg.sv
hw/rtl/gfau_mul.sv
hw/rtl/galois_field_arithmetic_unit.sv
test/galois_field_arithmetic_unit_tb.sv
